@@ hdl/lrutss_pkg.sv @@
// Shared types and field widths for the timestamp LRU replacement stats unit.
package lrutss_pkg;

   localparam int KIND_W  = 1;
   localparam int SET_W   = 6;
   localparam int WAY_W   = 4;
   localparam int STAMP_W = 48;
   localparam int OCC_W   = 5;

   localparam logic [KIND_W-1:0] KIND_QUERY  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_TREE  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;   // write a zero row at the clear pointer
      logic start;      // capture item, issue row read
      logic load;       // row data present: capture stats and leaves, write back
      logic finish;     // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last; // clear pointer is at the last row
   } sts_type;

endpackage

@@ hdl/lru_timestamp_replacement_stats_unit.sv @@
// Top level: timestamp LRU victim select and per-access line statistics.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------
//   req     | in  | req_valid/req_ready  | kind, set_index, way_index, wr_flag, hit, now
//   rsp     | out | rsp_valid/rsp_ready  | victim_way, age, line_valid, line_dirty, occupancy
//
// One item is in flight at a time and passes these steps in order:
// accept and row read, row capture with write-back, one step per level of the
// registered min/count tree over the ways, then the result register load.
// After reset a clearing pass writes SETS zero rows (one row per cycle) into the
// set RAM; req_ready stays low until it ends.
// A result waits in the output register while the next item is accepted and worked;
// that item stalls only at its final step until the pending result is taken.
//
// Each RAM row holds one set: per way a 48-bit last-use stamp, valid and dirty.
// Ties on the stamp go to the lowest way. Write hits report stats but leave the
// line unchanged; any other update stamps the line, sets valid, dirty = wr_flag.
module lru_timestamp_replacement_stats_unit #(
   parameter int SETS = 64,
   parameter int WAYS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lrutss_pkg::KIND_W-1:0]     req_kind,
   input  logic [lrutss_pkg::SET_W-1:0]      req_set_index,
   input  logic [lrutss_pkg::WAY_W-1:0]      req_way_index,
   input  logic                              req_wr_flag,
   input  logic                              req_hit,
   input  logic [lrutss_pkg::STAMP_W-1:0]    req_now,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lrutss_pkg::WAY_W-1:0]      rsp_victim_way,
   output logic [lrutss_pkg::STAMP_W-1:0]    rsp_age,
   output logic                              rsp_line_valid,
   output logic                              rsp_line_dirty,
   output logic [lrutss_pkg::OCC_W-1:0]      rsp_occupancy
);
   import lrutss_pkg::*;

   localparam int LVL = (WAYS > 1) ? $clog2(WAYS) : 0;

   cmd_type cmd;
   sts_type sts;

   lrutss_ctrl #(
      .TREE_LEVELS (LVL)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lrutss_dp #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_kind),
      .req_set_index  (req_set_index),
      .req_way_index  (req_way_index),
      .req_wr_flag    (req_wr_flag),
      .req_hit        (req_hit),
      .req_now        (req_now),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_victim_way (rsp_victim_way),
      .rsp_age        (rsp_age),
      .rsp_line_valid (rsp_line_valid),
      .rsp_line_dirty (rsp_line_dirty),
      .rsp_occupancy  (rsp_occupancy)
   );

   // at most one datapath command per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_en, cmd.start, cmd.load, cmd.finish}))
      else $error("more than one datapath command active");

   // no item taken while the clearing pass runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_en && req_ready))
      else $error("input ready during clearing pass");

   // the row read issued at accept is consumed in the next cycle
   a_start_then_load: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.load)
      else $error("row load did not follow accept");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while pending");

endmodule

@@ hdl/lrutss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lrutss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lrutss_ctrl.sv @@
// Sequencing state machine: clear sweep, row read, tree wait, result hand-off.
module lrutss_ctrl #(
   parameter int TREE_LEVELS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lrutss_pkg::cmd_type  cmd,
   input  lrutss_pkg::sts_type  sts
);
   import lrutss_pkg::*;

   localparam int TCW = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

   state_type      state_ff, state_in;
   logic [TCW-1:0] tree_cnt_ff, tree_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           tree_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign tree_last = (tree_cnt_ff == TCW'(TREE_LEVELS - 1));

   always_comb begin
      state_in    = state_ff;
      tree_cnt_in = tree_cnt_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load    = 1'b1;
            tree_cnt_in = '0;
            state_in    = (TREE_LEVELS == 0) ? ST_DONE : ST_TREE;
         end
         ST_TREE: begin
            tree_cnt_in = tree_cnt_ff + TCW'(1);
            if (tree_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         tree_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tree_cnt_ff  <= tree_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/lrutss_dp.sv @@
// Datapath: set row RAM, item registers, registered min/count tree, result register.
module lrutss_dp #(
   parameter int SETS = 64,
   parameter int WAYS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lrutss_pkg::KIND_W-1:0]     req_kind,
   input  logic [lrutss_pkg::SET_W-1:0]      req_set_index,
   input  logic [lrutss_pkg::WAY_W-1:0]      req_way_index,
   input  logic                              req_wr_flag,
   input  logic                              req_hit,
   input  logic [lrutss_pkg::STAMP_W-1:0]    req_now,
   input  lrutss_pkg::cmd_type               cmd,
   output lrutss_pkg::sts_type               sts,
   output logic [lrutss_pkg::WAY_W-1:0]      rsp_victim_way,
   output logic [lrutss_pkg::STAMP_W-1:0]    rsp_age,
   output logic                              rsp_line_valid,
   output logic                              rsp_line_dirty,
   output logic [lrutss_pkg::OCC_W-1:0]      rsp_occupancy
);
   import lrutss_pkg::*;

   localparam int SA     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WA     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LVL    = (WAYS > 1) ? $clog2(WAYS) : 0;
   localparam int LEAVES = 1 << LVL;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int CW     = $clog2(WAYS + 1);
   localparam int EW     = STAMP_W + 2;     // {dirty, valid, stamp}
   localparam int SET_N  = 1 << SET_W;
   localparam int WAY_N  = 1 << WAY_W;

   // index reduction tables (modulo the configured geometry)
   logic [SA-1:0] set_map [SET_N];
   logic [WA-1:0] way_map [WAY_N];

   for (genvar gs = 0; gs < SET_N; gs++) begin : g_set_map
      assign set_map[gs] = SA'(gs % SETS);
   end
   for (genvar gw = 0; gw < WAY_N; gw++) begin : g_way_map
      assign way_map[gw] = WA'(gw % WAYS);
   end

   // item registers
   logic [KIND_W-1:0]  kind_ff,  kind_in;
   logic [SA-1:0]      set_ff,   set_in;
   logic [WA-1:0]      way_ff,   way_in;
   logic               wr_ff,    wr_in;
   logic               hit_ff,   hit_in;
   logic [STAMP_W-1:0] now_ff,   now_in;

   // line statistics captured from the row
   logic [STAMP_W-1:0] age_ff,    age_in;
   logic               lvalid_ff, lvalid_in;
   logic               ldirty_ff, ldirty_in;

   // clear sweep pointer
   logic [SA-1:0]      clr_ptr_ff, clr_ptr_in;

   // result register
   logic [WAY_W-1:0]   victim_ff, victim_in;
   logic [STAMP_W-1:0] oage_ff,   oage_in;
   logic               ovalid_ff, ovalid_in;
   logic               odirty_ff, odirty_in;
   logic [OCC_W-1:0]   occ_ff,    occ_in;

   // RAM interface
   logic [WAYS-1:0][EW-1:0] row_rd;
   logic [WAYS-1:0][EW-1:0] row_new;
   logic [WAYS-1:0][EW-1:0] ram_wr_data;
   logic [SA-1:0]           ram_wr_addr;
   logic                    ram_wr_en;
   logic [EW-1:0]           line_entry;

   // tree nodes, heap order: node 0 is the root, leaves at LEAVES-1 upward
   logic [STAMP_W-1:0] leaf_stamp [LEAVES];
   logic [WA-1:0]      leaf_way   [LEAVES];
   logic [CW-1:0]      leaf_cnt   [LEAVES];
   logic [STAMP_W-1:0] node_stamp_ff [NODES];
   logic [STAMP_W-1:0] node_stamp_in [NODES];
   logic [WA-1:0]      node_way_ff   [NODES];
   logic [WA-1:0]      node_way_in   [NODES];
   logic [CW-1:0]      node_cnt_ff   [NODES];
   logic [CW-1:0]      node_cnt_in   [NODES];

   logic [WA+WAY_W-1:0] victim_ext;
   logic [CW+OCC_W-1:0] occ_ext;

   lrutss_ram #(
      .WIDTH (WAYS * EW),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.start),
      .rd_addr (set_map[req_set_index]),
      .rd_data (row_rd)
   );

   // ---- item capture ----
   always_comb begin
      kind_in = kind_ff;
      set_in  = set_ff;
      way_in  = way_ff;
      wr_in   = wr_ff;
      hit_in  = hit_ff;
      now_in  = now_ff;
      if (cmd.start) begin
         kind_in = req_kind;
         set_in  = set_map[req_set_index];
         way_in  = way_map[req_way_index];
         wr_in   = req_wr_flag;
         hit_in  = req_hit;
         now_in  = req_now;
      end
   end

   // ---- line stats and write-back ----
   assign line_entry = row_rd[way_ff];

   always_comb begin
      row_new         = row_rd;
      row_new[way_ff] = {wr_ff, 1'b1, now_ff};
   end

   always_comb begin
      age_in    = age_ff;
      lvalid_in = lvalid_ff;
      ldirty_in = ldirty_ff;
      if (cmd.load) begin
         age_in    = now_ff - line_entry[STAMP_W-1:0];
         lvalid_in = line_entry[STAMP_W];
         ldirty_in = line_entry[STAMP_W+1];
      end
   end

   // write hits leave the line untouched
   assign ram_wr_en   = cmd.clear_en ||
                        (cmd.load && (kind_ff == KIND_UPDATE) && !(hit_ff && wr_ff));
   assign ram_wr_addr = cmd.clear_en ? clr_ptr_ff : set_ff;
   assign ram_wr_data = cmd.clear_en ? '0 : row_new;

   assign clr_ptr_in     = cmd.clear_en ? (clr_ptr_ff + SA'(1)) : clr_ptr_ff;
   assign sts.clear_last = (clr_ptr_ff == SA'(SETS - 1));

   // ---- leaves: real ways, then padding that never wins ----
   for (genvar gl = 0; gl < LEAVES; gl++) begin : g_leaf
      if (gl < WAYS) begin : g_real
         assign leaf_stamp[gl] = row_rd[gl][STAMP_W-1:0];
         assign leaf_way[gl]   = WA'(gl);
         assign leaf_cnt[gl]   = CW'(row_rd[gl][STAMP_W]);
      end else begin : g_pad
         assign leaf_stamp[gl] = '1;
         assign leaf_way[gl]   = WA'(gl);
         assign leaf_cnt[gl]   = '0;
      end
   end

   // ---- one tree level per cycle; right child wins only when strictly older ----
   always_comb begin
      node_stamp_in = node_stamp_ff;
      node_way_in   = node_way_ff;
      node_cnt_in   = node_cnt_ff;
      for (int i = 0; i < LEAVES - 1; i++) begin
         if (node_stamp_ff[2*i+2] < node_stamp_ff[2*i+1]) begin
            node_stamp_in[i] = node_stamp_ff[2*i+2];
            node_way_in[i]   = node_way_ff[2*i+2];
         end else begin
            node_stamp_in[i] = node_stamp_ff[2*i+1];
            node_way_in[i]   = node_way_ff[2*i+1];
         end
         node_cnt_in[i] = node_cnt_ff[2*i+1] + node_cnt_ff[2*i+2];
      end
      if (cmd.load) begin
         for (int i = 0; i < LEAVES; i++) begin
            node_stamp_in[LEAVES-1+i] = leaf_stamp[i];
            node_way_in[LEAVES-1+i]   = leaf_way[i];
            node_cnt_in[LEAVES-1+i]   = leaf_cnt[i];
         end
      end
   end

   // ---- result register ----
   assign victim_ext = {{WAY_W{1'b0}}, node_way_ff[0]};
   assign occ_ext    = {{OCC_W{1'b0}}, node_cnt_ff[0]};

   always_comb begin
      victim_in = victim_ff;
      oage_in   = oage_ff;
      ovalid_in = ovalid_ff;
      odirty_in = odirty_ff;
      occ_in    = occ_ff;
      if (cmd.finish) begin
         if (kind_ff == KIND_QUERY) begin
            victim_in = victim_ext[WAY_W-1:0];
            oage_in   = '0;
            ovalid_in = 1'b0;
            odirty_in = 1'b0;
            occ_in    = '0;
         end else begin
            victim_in = '0;
            oage_in   = age_ff;
            ovalid_in = lvalid_ff;
            odirty_in = ldirty_ff;
            occ_in    = occ_ext[OCC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      set_ff        <= set_in;
      way_ff        <= way_in;
      wr_ff         <= wr_in;
      hit_ff        <= hit_in;
      now_ff        <= now_in;
      age_ff        <= age_in;
      lvalid_ff     <= lvalid_in;
      ldirty_ff     <= ldirty_in;
      node_stamp_ff <= node_stamp_in;
      node_way_ff   <= node_way_in;
      node_cnt_ff   <= node_cnt_in;
      victim_ff     <= victim_in;
      oage_ff       <= oage_in;
      ovalid_ff     <= ovalid_in;
      odirty_ff     <= odirty_in;
      occ_ff        <= occ_in;
   end

   assign rsp_victim_way = victim_ff;
   assign rsp_age        = oage_ff;
   assign rsp_line_valid = ovalid_ff;
   assign rsp_line_dirty = odirty_ff;
   assign rsp_occupancy  = occ_ff;

endmodule

@@ test/tb_lru_timestamp_replacement_stats_unit.sv @@
// Testbench for the timestamp LRU replacement stats unit: directed and random traffic.
module tb_lru_timestamp_replacement_stats_unit;
   import lrutss_pkg::*;

   localparam int NUM_SETS    = 64;
   localparam int NUM_WAYS    = 16;
   localparam int NUM_LINES   = NUM_SETS * NUM_WAYS;
   localparam int IDLE_PCT    = 11;
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the block
   localparam int DRAIN_WAIT  = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SET_W-1:0]   set_index;
      logic [WAY_W-1:0]   way_index;
      logic               wr_flag;
      logic               hit;
      logic [STAMP_W-1:0] now;
   } access_item_type;

   typedef struct packed {
      logic [WAY_W-1:0]   victim_way;
      logic [STAMP_W-1:0] age;
      logic               line_valid;
      logic               line_dirty;
      logic [OCC_W-1:0]   occupancy;
   } lru_result_type;

   // DUT ports; every input starts at a known value
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [KIND_W-1:0]  req_kind = KIND_QUERY;
   logic [SET_W-1:0]   req_set_index = '0;
   logic [WAY_W-1:0]   req_way_index = '0;
   logic               req_wr_flag = 1'b0;
   logic               req_hit = 1'b0;
   logic [STAMP_W-1:0] req_now = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [WAY_W-1:0]   rsp_victim_way;
   logic [STAMP_W-1:0] rsp_age;
   logic               rsp_line_valid;
   logic               rsp_line_dirty;
   logic [OCC_W-1:0]   rsp_occupancy;

   // shadow copy of the per-line state, indexed by set * ways + way
   logic [STAMP_W-1:0] stamp_shadow [NUM_LINES];
   bit                 valid_shadow [NUM_LINES];
   bit                 dirty_shadow [NUM_LINES];

   lru_result_type pending_results[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             idle_enable = 1'b1;
   bit             hold_pending = 1'b0;
   int             hold_left = 0;

   lru_timestamp_replacement_stats_unit #(
      .SETS(NUM_SETS),
      .WAYS(NUM_WAYS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_set_index (req_set_index),
      .req_way_index (req_way_index),
      .req_wr_flag   (req_wr_flag),
      .req_hit       (req_hit),
      .req_now       (req_now),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_victim_way(rsp_victim_way),
      .rsp_age       (rsp_age),
      .rsp_line_valid(rsp_line_valid),
      .rsp_line_dirty(rsp_line_dirty),
      .rsp_occupancy (rsp_occupancy)
   );

   always #6 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Works out the result of one accepted item and applies its side effects
   // to the shadow state. Query: oldest stamp wins, lowest way on a tie.
   // Update: stats come from the state before the item; a write hit leaves
   // the line alone, anything else restamps it.
   function automatic lru_result_type apply_lru_access(input access_item_type it);
      lru_result_type r;
      int             base;
      int             line;
      int             oldest;
      r    = '0;
      base = int'(it.set_index) * NUM_WAYS;
      line = base + int'(it.way_index);
      if (it.kind == KIND_QUERY) begin
         oldest = 0;
         for (int w = 1; w < NUM_WAYS; w++) begin
            if (stamp_shadow[base + w] < stamp_shadow[base + oldest])
               oldest = w;
         end
         r.victim_way = oldest[WAY_W-1:0];
      end else begin
         for (int w = 0; w < NUM_WAYS; w++)
            r.occupancy += OCC_W'(valid_shadow[base + w]);
         r.age        = it.now - stamp_shadow[line];
         r.line_valid = valid_shadow[line];
         r.line_dirty = dirty_shadow[line];
         if (!(it.hit && it.wr_flag)) begin
            stamp_shadow[line] = it.now;
            valid_shadow[line] = 1'b1;
            dirty_shadow[line] = it.wr_flag;
         end
      end
      return r;
   endfunction

   function automatic access_item_type make_item(input logic [KIND_W-1:0] kind,
                                                 input int set_i, input int way_i,
                                                 input bit wr, input bit hit,
                                                 input logic [STAMP_W-1:0] now);
      access_item_type it;
      it.kind      = kind;
      it.set_index = set_i[SET_W-1:0];
      it.way_index = way_i[WAY_W-1:0];
      it.wr_flag   = wr;
      it.hit       = hit;
      it.now       = now;
      return it;
   endfunction

   // Fully random item; a slice of them use tiny stamps so ties show up.
   function automatic access_item_type random_item();
      logic [STAMP_W-1:0] now;
      now = STAMP_W'({$urandom, $urandom});
      if ($urandom_range(99) < 20)
         now = STAMP_W'($urandom_range(7));
      return make_item($urandom_range(1) ? KIND_UPDATE : KIND_QUERY, $urandom_range(63),
                       $urandom_range(15), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       now);
   endfunction

   // Sender: optional random gap, then hold valid until accepted. Valid is
   // only dropped in a gap, so back-to-back items keep it high.
   task automatic send_item(input access_item_type it);
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= it.kind;
      req_set_index <= it.set_index;
      req_way_index <= it.way_index;
      req_wr_flag   <= it.wr_flag;
      req_hit       <= it.hit;
      req_now       <= it.now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_lru_access(it));
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_pending) begin
         hold_left    = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      lru_result_type exp_r;
      lru_result_type got_r;
      if (!reset && rsp_valid && rsp_ready) begin
         got_r = {rsp_victim_way, rsp_age, rsp_line_valid, rsp_line_dirty, rsp_occupancy};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display({"result with nothing outstanding: ",
                         "victim %0d age %h v %0d d %0d occ %0d"},
                        got_r.victim_way, got_r.age, got_r.line_valid, got_r.line_dirty,
                        got_r.occupancy);
         end else begin
            exp_r = pending_results.pop_front();
            if (got_r.victim_way !== exp_r.victim_way || got_r.age !== exp_r.age ||
                got_r.line_valid !== exp_r.line_valid ||
                got_r.line_dirty !== exp_r.line_dirty ||
                got_r.occupancy !== exp_r.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display({"bad result at cycle %0d: ",
                            "exp victim %0d age %h v %0d d %0d occ %0d, ",
                            "got victim %0d age %h v %0d d %0d occ %0d"},
                           cycle_count, exp_r.victim_way, exp_r.age, exp_r.line_valid,
                           exp_r.line_dirty, exp_r.occupancy, got_r.victim_way, got_r.age,
                           got_r.line_valid, got_r.line_dirty, got_r.occupancy);
            end
         end
      end
   end

   // Extremes and corner cases: fresh sets, write hit on an empty line,
   // stamp wrap, dirty tracking, full set and victim ordering.
   task automatic test_directed();
      send_item(make_item(KIND_QUERY, 0, 0, 1'b0, 1'b0, '0));
      send_item(make_item(KIND_QUERY, 63, 15, 1'b1, 1'b1, '1));
      // write hit on a never-used line: stats only, nothing changes
      send_item(make_item(KIND_UPDATE, 63, 15, 1'b1, 1'b1, '1));
      send_item(make_item(KIND_QUERY, 63, 0, 1'b0, 1'b0, '0));
      send_item(make_item(KIND_UPDATE, 63, 15, 1'b1, 1'b0, 48'h5));
      // read hit with a now that lands far ahead; clears dirty
      send_item(make_item(KIND_UPDATE, 63, 15, 1'b0, 1'b1, '1));
      // write hit with now behind the stamp: age wraps
      send_item(make_item(KIND_UPDATE, 63, 15, 1'b1, 1'b1, 48'h3));
      send_item(make_item(KIND_UPDATE, 63, 15, 1'b0, 1'b0, '0));
      // all stamps tie at zero now; lowest way wins
      send_item(make_item(KIND_QUERY, 63, 0, 1'b0, 1'b0, '0));
      // fill one set with descending stamps so the top way is oldest
      for (int w = 0; w < NUM_WAYS; w++)
         send_item(make_item(KIND_UPDATE, 10, w, 1'(w % 2), 1'b0,
                             STAMP_W'(2000 - 10 * w)));
      send_item(make_item(KIND_QUERY, 10, 0, 1'b0, 1'b0, '0));
      send_item(make_item(KIND_UPDATE, 10, 15, 1'b0, 1'b1, STAMP_W'(5000)));
      send_item(make_item(KIND_QUERY, 10, 0, 1'b0, 1'b0, '0));
   endtask

   // Realistic traffic: a few hot sets, a clock that only moves forward
   // (and wraps past the top), mixed with fully random noise items.
   task automatic test_lru_traffic(input int n_items);
      int                 hot_sets[4];
      logic [STAMP_W-1:0] clk_now;
      access_item_type    it;
      for (int i = 0; i < 4; i++)
         hot_sets[i] = $urandom_range(63);
      clk_now = '1 - STAMP_W'($urandom_range(4000));
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 80) begin
            clk_now += STAMP_W'($urandom_range(40));
            it = make_item(($urandom_range(99) < 30) ? KIND_QUERY : KIND_UPDATE,
                           hot_sets[$urandom_range(3)], $urandom_range(15),
                           1'($urandom_range(1)), 1'($urandom_range(1)), clk_now);
         end else begin
            it = random_item();
         end
         send_item(it);
      end
   endtask

   // Receiver stops for a long stretch while items keep coming.
   task automatic test_output_hold();
      hold_pending = 1'b1;
      test_lru_traffic(60);
   endtask

   // Back-to-back items with no gaps on either side.
   task automatic test_no_idle();
      idle_enable = 1'b0;
      test_lru_traffic(200);
      idle_enable = 1'b1;
   endtask

   task automatic test_noise(input int n_items);
      for (int i = 0; i < n_items; i++)
         send_item(random_item());
   endtask

   initial begin
      for (int i = 0; i < NUM_LINES; i++) begin
         stamp_shadow[i] = '0;
         valid_shadow[i] = 1'b0;
         dirty_shadow[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_lru_traffic(400);
      test_output_hold();
      test_no_idle();
      test_noise(210);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
